// ===== hw/rtl/tste_pkg.sv =====
`timescale 1ns / 1ps

package tste_pkg;

    localparam int HOUR_W           = 5;
    localparam int MIN_W            = 6;
    localparam int REQ_W            = 3;
    localparam int SLOT_OUT_W       = 3;
    localparam int KEY_W            = 11;
    localparam int MINUTES_PER_HOUR = 60;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 3'd0,
        REQ_REMOVE = 3'd1,
        REQ_NEXT   = 3'd2,
        REQ_PREV   = 3'd3,
        REQ_SORT   = 3'd4,
        REQ_READ   = 3'd5,
        REQ_CLEAR  = 3'd6
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SCAN,
        ST_RPT,
        ST_SORT_LOAD,
        ST_SORT_FIRST,
        ST_SORT_STEP,
        ST_SORT_TAIL
    } state_t;

    typedef struct packed {
        logic [HOUR_W-1:0] hours;
        logic [MIN_W-1:0]  minutes;
        logic              action;
    } data_t;

    typedef struct packed {
        logic  written;
        logic  valid;
        data_t data;
    } slot_t;

endpackage

// ===== hw/rtl/tste_key_cmp.sv =====
`timescale 1ns / 1ps

module tste_key_cmp
(
    input  tste_pkg::slot_t a,
    input  tste_pkg::slot_t b,
    output logic            a_gt_b
);

    import tste_pkg::*;

    logic [KEY_W-1:0] key_a;
    logic [KEY_W-1:0] key_b;

    // An empty slot sorts with key zero.
    always_comb
    begin
        key_a = '0;
        key_b = '0;
        if (a.valid)
        begin
            key_a = KEY_W'(a.data.hours) * KEY_W'(MINUTES_PER_HOUR) + KEY_W'(a.data.minutes);
        end
        if (b.valid)
        begin
            key_b = KEY_W'(b.data.hours) * KEY_W'(MINUTES_PER_HOUR) + KEY_W'(b.data.minutes);
        end
    end

    assign a_gt_b = key_a > key_b;

endmodule

// ===== hw/rtl/time_slot_table_engine.sv =====
`timescale 1ns / 1ps

// Channel   Handshake                 Fields
// request   start, accepted if !busy  req_type, slot_index, hours_in, minutes_in, action_in
// result    done, one-cycle strobe    found, slot_out, entry_valid, hours_out, minutes_out,
//                                     action_out
//
// Remove, clear, unused codes and a read with an out-of-range index strobe done in the cycle
// after the transaction; busy stays low. Add and search scan one slot per cycle; next and prev
// first reduce the start index below SLOTS; a read, and a search that hits, then fetch the entry.
// Sort runs one bubble pass per step of the pass counter, one compare per cycle through the
// key comparator. Reset empties the whole table at once. The receiver cannot stall the result.

module time_slot_table_engine #(
    parameter int SLOTS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] req_type,
    input  logic [2:0] slot_index,
    input  logic [4:0] hours_in,
    input  logic [5:0] minutes_in,
    input  logic       action_in,
    output logic       done,
    output logic       found,
    output logic [2:0] slot_out,
    output logic       entry_valid,
    output logic [4:0] hours_out,
    output logic [5:0] minutes_out,
    output logic       action_out
);

    import tste_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int SW = (IW > 3) ? IW : 3;
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    state_t state_reg, state_next;

    logic [REQ_W-1:0] req_reg, req_next;
    data_t            din_reg, din_next;
    logic [IW-1:0]    k_reg, k_next;
    logic [IW-1:0]    cnt_reg, cnt_next;
    logic [IW-1:0]    j_reg, j_next;
    logic [IW-1:0]    lim_reg, lim_next;
    logic [SW-1:0]    st_reg, st_next;
    slot_t            carry_reg, carry_next;
    logic [SLOTS-1:0] v_reg, v_next;
    logic [SLOTS-1:0] w_reg, w_next;

    logic                  done_reg, done_next;
    logic                  found_reg, found_next;
    logic [SLOT_OUT_W-1:0] slot_reg, slot_next;
    logic                  ev_reg, ev_next;
    data_t                 res_reg, res_next;

    data_t         mem [SLOTS];
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    data_t         mem_wdata;
    logic [IW-1:0] mem_raddr;
    data_t         mem_rdata_reg;
    logic [IW-1:0] raddr_reg;

    slot_t         rd_slot;
    logic          gt;
    logic          in_range;
    logic [IW-1:0] idx_k;
    logic [IW-1:0] st_k;
    logic          st_ge;
    logic          hit;
    logic          is_add;
    logic          is_prev;
    logic          last_step;

    function automatic logic [IW-1:0] step_fwd(input logic [IW-1:0] x);
        logic [IW-1:0] r;
        r = (x == LAST) ? '0 : IW'(x + 1'b1);
        return r;
    endfunction

    function automatic logic [IW-1:0] step_back(input logic [IW-1:0] x);
        logic [IW-1:0] r;
        r = (x == '0) ? LAST : IW'(x - 1'b1);
        return r;
    endfunction

    assign in_range  = 32'(slot_index) < SLOTS;
    assign idx_k     = IW'(slot_index);
    assign st_k      = st_reg[IW-1:0];
    assign st_ge     = 32'(st_reg) >= SLOTS;
    assign is_add    = req_reg == REQ_ADD;
    assign is_prev   = req_reg == REQ_PREV;
    assign hit       = is_add ? !v_reg[k_reg] : v_reg[k_reg];
    assign last_step = IW'(j_reg + 1'b1) == lim_reg;

    assign rd_slot.written = w_reg[raddr_reg];
    assign rd_slot.valid   = v_reg[raddr_reg];
    assign rd_slot.data    = w_reg[raddr_reg] ? mem_rdata_reg : '0;

    tste_key_cmp u_cmp
    (
        .a      (carry_reg),
        .b      (rd_slot),
        .a_gt_b (gt)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (req_type)
                        REQ_ADD:
                        begin
                            state_next = ST_SCAN;
                        end
                        REQ_NEXT, REQ_PREV:
                        begin
                            state_next = ST_REDUCE;
                        end
                        REQ_SORT:
                        begin
                            state_next = ST_SORT_LOAD;
                        end
                        REQ_READ:
                        begin
                            if (in_range)
                            begin
                                state_next = ST_RPT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_REDUCE:
            begin
                if (!st_ge)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = is_add ? ST_IDLE : ST_RPT;
                end
                else if (cnt_reg == LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RPT:
            begin
                state_next = ST_IDLE;
            end
            ST_SORT_LOAD:
            begin
                state_next = ST_SORT_FIRST;
            end
            ST_SORT_FIRST:
            begin
                state_next = ST_SORT_STEP;
            end
            ST_SORT_STEP:
            begin
                if (last_step)
                begin
                    state_next = ST_SORT_TAIL;
                end
            end
            ST_SORT_TAIL:
            begin
                state_next = (lim_reg == IW'(1)) ? ST_IDLE : ST_SORT_LOAD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_next    = req_reg;
        din_next    = din_reg;
        k_next      = k_reg;
        cnt_next    = cnt_reg;
        j_next      = j_reg;
        lim_next    = lim_reg;
        st_next     = st_reg;
        carry_next  = carry_reg;
        v_next      = v_reg;
        w_next      = w_reg;
        done_next   = 1'b0;
        found_next  = 1'b0;
        slot_next   = '0;
        ev_next     = 1'b0;
        res_next    = '0;
        mem_we      = 1'b0;
        mem_waddr   = j_reg;
        mem_wdata   = carry_reg.data;
        mem_raddr   = k_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next = req_type;
                    din_next = '{hours: hours_in, minutes: minutes_in, action: action_in};
                    unique case (req_type)
                        REQ_ADD:
                        begin
                            k_next   = '0;
                            cnt_next = '0;
                        end
                        REQ_REMOVE:
                        begin
                            done_next = 1'b1;
                            if (in_range)
                            begin
                                v_next[idx_k] = 1'b0;
                                found_next    = 1'b1;
                                slot_next     = slot_index;
                            end
                        end
                        REQ_NEXT, REQ_PREV:
                        begin
                            st_next = SW'(slot_index);
                        end
                        REQ_SORT:
                        begin
                            lim_next = LAST;
                        end
                        REQ_READ:
                        begin
                            if (in_range)
                            begin
                                k_next    = idx_k;
                                mem_raddr = idx_k;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            v_next    = '0;
                            w_next    = '0;
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_REDUCE:
            begin
                if (st_ge)
                begin
                    st_next = SW'(st_reg - SW'(SLOTS));
                end
                else
                begin
                    k_next   = is_prev ? step_back(st_k) : step_fwd(st_k);
                    cnt_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    if (is_add)
                    begin
                        mem_we        = 1'b1;
                        mem_waddr     = k_reg;
                        mem_wdata     = din_reg;
                        v_next[k_reg] = 1'b1;
                        w_next[k_reg] = 1'b1;
                        done_next     = 1'b1;
                        found_next    = 1'b1;
                        slot_next     = SLOT_OUT_W'(k_reg);
                        ev_next       = 1'b1;
                        res_next      = din_reg;
                    end
                end
                else if (cnt_reg == LAST)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    k_next   = is_prev ? step_back(k_reg) : step_fwd(k_reg);
                    cnt_next = IW'(cnt_reg + 1'b1);
                end
            end
            ST_RPT:
            begin
                done_next  = 1'b1;
                found_next = 1'b1;
                slot_next  = SLOT_OUT_W'(k_reg);
                ev_next    = rd_slot.valid;
                res_next   = rd_slot.data;
            end
            ST_SORT_LOAD:
            begin
                mem_raddr = '0;
            end
            ST_SORT_FIRST:
            begin
                carry_next = rd_slot;
                j_next     = '0;
                mem_raddr  = IW'(1);
            end
            ST_SORT_STEP:
            begin
                // The larger key travels on; the smaller one settles at the current place.
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                if (gt)
                begin
                    mem_wdata     = rd_slot.data;
                    v_next[j_reg] = rd_slot.valid;
                    w_next[j_reg] = rd_slot.written;
                end
                else
                begin
                    mem_wdata     = carry_reg.data;
                    v_next[j_reg] = carry_reg.valid;
                    w_next[j_reg] = carry_reg.written;
                    carry_next    = rd_slot;
                end
                if (!last_step)
                begin
                    j_next    = IW'(j_reg + 1'b1);
                    mem_raddr = IW'(j_reg + IW'(2));
                end
            end
            ST_SORT_TAIL:
            begin
                mem_we          = 1'b1;
                mem_waddr       = lim_reg;
                mem_wdata       = carry_reg.data;
                v_next[lim_reg] = carry_reg.valid;
                w_next[lim_reg] = carry_reg.written;
                if (lim_reg == IW'(1))
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    lim_next = IW'(lim_reg - 1'b1);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            v_reg     <= '0;
            w_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v_reg     <= v_next;
            w_reg     <= w_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        din_reg   <= din_next;
        k_reg     <= k_next;
        cnt_reg   <= cnt_next;
        j_reg     <= j_next;
        lim_reg   <= lim_next;
        st_reg    <= st_next;
        carry_reg <= carry_next;
        found_reg <= found_next;
        slot_reg  <= slot_next;
        ev_reg    <= ev_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
        raddr_reg     <= mem_raddr;
    end

    assign busy        = state_reg != ST_IDLE;
    assign done        = done_reg;
    assign found       = found_reg;
    assign slot_out    = slot_reg;
    assign entry_valid = ev_reg;
    assign hours_out   = res_reg.hours;
    assign minutes_out = res_reg.minutes;
    assign action_out  = res_reg.action;

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction neither started work nor gave a result");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (slot_out == '0 && !entry_valid && hours_out == '0 &&
                              minutes_out == '0 && !action_out))
        else $error("result fields not zero when nothing was found");

    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a transaction");

    a_valid_written: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg & ~w_reg) == '0)
        else $error("slot marked valid without stored data");

endmodule

// ===== dv/time_slot_table_engine_test.sv =====
`timescale 1ns / 1ps

module time_slot_table_engine_test;

    import tste_pkg::*;

    localparam int SLOTS = 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 64;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

    typedef struct packed {
        logic                  found;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  valid;
        logic [HOUR_W-1:0]     hours;
        logic [MIN_W-1:0]      minutes;
        logic                  action;
    } table_result_t;

    class slot_table_model;
        bit                vld  [SLOTS];
        bit [HOUR_W-1:0]   hrs  [SLOTS];
        bit [MIN_W-1:0]    mins [SLOTS];
        bit                act  [SLOTS];
        table_result_t     expected_results[$];
        int                errors;

        function new();
            errors = 0;
            clear_table();
        endfunction

        function void clear_table();
            for (int i = 0; i < SLOTS; i++)
            begin
                vld[i]  = 1'b0;
                hrs[i]  = '0;
                mins[i] = '0;
                act[i]  = 1'b0;
            end
        endfunction

        function int sort_key(int k);
            if (!vld[k])
                return 0;
            return int'(hrs[k]) * MINUTES_PER_HOUR + int'(mins[k]);
        endfunction

        function table_result_t slot_report(int k);
            table_result_t r;
            r.found   = 1'b1;
            r.slot    = SLOT_OUT_W'(k);
            r.valid   = vld[k];
            r.hours   = hrs[k];
            r.minutes = mins[k];
            r.action  = act[k];
            return r;
        endfunction

        function table_result_t apply_request(logic [REQ_W-1:0] req, logic [2:0] idx,
                                              logic [HOUR_W-1:0] h, logic [MIN_W-1:0] m,
                                              logic a);
            table_result_t r;
            bit            hit;
            int            k;
            bit            tv;
            bit [HOUR_W-1:0] th;
            bit [MIN_W-1:0]  tm;
            bit            ta;
            r   = '0;
            hit = 1'b0;
            case (req)
                REQ_ADD:
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!hit && !vld[i])
                        begin
                            vld[i]  = 1'b1;
                            hrs[i]  = h;
                            mins[i] = m;
                            act[i]  = a;
                            r       = slot_report(i);
                            hit     = 1'b1;
                        end
                    end
                end
                REQ_REMOVE:
                begin
                    if (int'(idx) < SLOTS)
                    begin
                        vld[idx] = 1'b0;
                        r.found  = 1'b1;
                        r.slot   = idx;
                    end
                end
                REQ_NEXT:
                begin
                    for (int i = 1; i <= SLOTS; i++)
                    begin
                        k = (int'(idx) + i) % SLOTS;
                        if (!hit && vld[k])
                        begin
                            r   = slot_report(k);
                            hit = 1'b1;
                        end
                    end
                end
                REQ_PREV:
                begin
                    for (int i = 1; i <= SLOTS; i++)
                    begin
                        k = ((int'(idx) % SLOTS) + SLOTS - i) % SLOTS;
                        if (!hit && vld[k])
                        begin
                            r   = slot_report(k);
                            hit = 1'b1;
                        end
                    end
                end
                REQ_SORT:
                begin
                    for (int i = 0; i + 1 < SLOTS; i++)
                    begin
                        for (int j = 0; j + 1 < SLOTS - i; j++)
                        begin
                            if (sort_key(j) > sort_key(j + 1))
                            begin
                                tv = vld[j];  vld[j]  = vld[j+1];  vld[j+1]  = tv;
                                th = hrs[j];  hrs[j]  = hrs[j+1];  hrs[j+1]  = th;
                                tm = mins[j]; mins[j] = mins[j+1]; mins[j+1] = tm;
                                ta = act[j];  act[j]  = act[j+1];  act[j+1]  = ta;
                            end
                        end
                    end
                end
                REQ_READ:
                begin
                    if (int'(idx) < SLOTS)
                        r = slot_report(int'(idx));
                end
                REQ_CLEAR:
                begin
                    clear_table();
                end
                default:
                begin
                end
            endcase
            return r;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task report(string msg);
            $display("ERROR at %0t ns: %s", $time, msg);
            errors++;
        endtask

        task note_request(logic [REQ_W-1:0] req, logic [2:0] idx, logic [HOUR_W-1:0] h,
                          logic [MIN_W-1:0] m, logic a);
            expected_results.push_back(apply_request(req, idx, h, m, a));
        endtask

        task check_result(table_result_t got);
            table_result_t want;
            if (expected_results.size() == 0)
            begin
                report($sformatf("result with no transaction waiting: %p", got));
                return;
            end
            want = expected_results.pop_front();
            if (got.found !== want.found)
                report($sformatf("found %b, expected %b", got.found, want.found));
            if (got.slot !== want.slot)
                report($sformatf("slot_out %0d, expected %0d", got.slot, want.slot));
            if (got.valid !== want.valid)
                report($sformatf("entry_valid %b, expected %b", got.valid, want.valid));
            if (got.hours !== want.hours)
                report($sformatf("hours_out %0d, expected %0d", got.hours, want.hours));
            if (got.minutes !== want.minutes)
                report($sformatf("minutes_out %0d, expected %0d", got.minutes, want.minutes));
            if (got.action !== want.action)
                report($sformatf("action_out %b, expected %b", got.action, want.action));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [REQ_W-1:0]      req_type;
    logic [2:0]            slot_index;
    logic [HOUR_W-1:0]     hours_in;
    logic [MIN_W-1:0]      minutes_in;
    logic                  action_in;
    logic                  done;
    logic                  found;
    logic [SLOT_OUT_W-1:0] slot_out;
    logic                  entry_valid;
    logic [HOUR_W-1:0]     hours_out;
    logic [MIN_W-1:0]      minutes_out;
    logic                  action_out;

    slot_table_model table_model;
    int              cycle_count;

    time_slot_table_engine #(
        .SLOTS(SLOTS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .slot_index  (slot_index),
        .hours_in    (hours_in),
        .minutes_in  (minutes_in),
        .action_in   (action_in),
        .done        (done),
        .found       (found),
        .slot_out    (slot_out),
        .entry_valid (entry_valid),
        .hours_out   (hours_out),
        .minutes_out (minutes_out),
        .action_out  (action_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                table_model.check_result({found, slot_out, entry_valid, hours_out,
                                          minutes_out, action_out});
            if (start && !busy)
                table_model.note_request(req_type, slot_index, hours_in, minutes_in,
                                         action_in);
        end
    end

    task send_request(logic [REQ_W-1:0] req, logic [2:0] idx, logic [HOUR_W-1:0] h,
                      logic [MIN_W-1:0] m, logic a);
        start      <= 1'b1;
        req_type   <= req;
        slot_index <= idx;
        hours_in   <= h;
        minutes_in <= m;
        action_in  <= a;
        do
            @(posedge clk);
        while (busy);
    endtask

    task idle_gap(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (table_model.pending() != 0)
            @(posedge clk);
    endtask

    task send_random_request();
        int                w;
        logic [REQ_W-1:0]  req;
        logic [HOUR_W-1:0] h;
        logic [MIN_W-1:0]  m;
        w = $urandom_range(0, 99);
        if (w < 35)
            req = REQ_ADD;
        else if (w < 50)
            req = REQ_REMOVE;
        else if (w < 62)
            req = REQ_NEXT;
        else if (w < 74)
            req = REQ_PREV;
        else if (w < 80)
            req = REQ_SORT;
        else if (w < 95)
            req = REQ_READ;
        else if (w < 98)
            req = REQ_CLEAR;
        else
            req = REQ_UNUSED;
        if ($urandom_range(0, 7) == 0)
            h = HOUR_W'($urandom_range(0, 31));
        else
            h = HOUR_W'($urandom_range(0, 23));
        if ($urandom_range(0, 7) == 0)
            m = MIN_W'($urandom_range(0, 63));
        else
            m = MIN_W'($urandom_range(0, 59));
        send_request(req, 3'($urandom_range(0, 7)), h, m, 1'($urandom_range(0, 1)));
    endtask

    task random_phase(int count, int gap_odds);
        for (int i = 0; i < count; i++)
        begin
            send_random_request();
            if (gap_odds > 0 && $urandom_range(0, gap_odds - 1) == 0)
                idle_gap($urandom_range(1, 11));
        end
    endtask

    initial
    begin
        table_model = new();
        cycle_count = 0;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        req_type   <= REQ_READ;
        slot_index <= '0;
        hours_in   <= '0;
        minutes_in <= '0;
        action_in  <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Searches, reads and sort on the empty table.
        send_request(REQ_READ, 3'd0, 5'd0, 6'd0, 1'b0);
        send_request(REQ_NEXT, 3'd0, 5'd0, 6'd0, 1'b0);
        send_request(REQ_PREV, 3'd0, 5'd0, 6'd0, 1'b0);
        send_request(REQ_SORT, 3'd0, 5'd0, 6'd0, 1'b0);

        // Fill every slot, including values beyond the time-of-day range.
        send_request(REQ_ADD, 3'd0, 5'd0, 6'd0, 1'b0);
        send_request(REQ_ADD, 3'd7, 5'd23, 6'd59, 1'b1);
        send_request(REQ_ADD, 3'd0, 5'd31, 6'd63, 1'b1);
        send_request(REQ_ADD, 3'd0, 5'd12, 6'd30, 1'b0);
        send_request(REQ_ADD, 3'd0, 5'd5, 6'd0, 1'b1);
        send_request(REQ_ADD, 3'd0, 5'd0, 6'd59, 1'b0);
        send_request(REQ_ADD, 3'd0, 5'd16, 6'd32, 1'b1);
        send_request(REQ_ADD, 3'd0, 5'd1, 6'd1, 1'b0);

        // The table is full, so this add must be refused.
        send_request(REQ_ADD, 3'd0, 5'd7, 6'd7, 1'b1);

        send_request(REQ_NEXT, 3'd7, 5'd0, 6'd0, 1'b0);
        send_request(REQ_PREV, 3'd0, 5'd0, 6'd0, 1'b0);
        send_request(REQ_REMOVE, 3'd3, 5'd0, 6'd0, 1'b0);
        send_request(REQ_READ, 3'd3, 5'd0, 6'd0, 1'b0);
        send_request(REQ_NEXT, 3'd2, 5'd0, 6'd0, 1'b0);
        send_request(REQ_PREV, 3'd4, 5'd0, 6'd0, 1'b0);
        send_request(REQ_SORT, 3'd0, 5'd0, 6'd0, 1'b0);
        send_request(REQ_READ, 3'd0, 5'd0, 6'd0, 1'b0);
        send_request(REQ_READ, 3'd7, 5'd0, 6'd0, 1'b0);
        send_request(REQ_UNUSED, 3'd5, 5'd31, 6'd63, 1'b1);
        send_request(REQ_CLEAR, 3'd0, 5'd0, 6'd0, 1'b0);
        send_request(REQ_READ, 3'd1, 5'd0, 6'd0, 1'b0);
        send_request(REQ_ADD, 3'd0, 5'd9, 6'd45, 1'b1);
        wait_drained();

        random_phase(500, 3);
        wait_drained();
        random_phase(500, 2);
        wait_drained();
        random_phase(600, 0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (table_model.errors == 0 && table_model.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/tste_pkg.sv
hw/rtl/tste_key_cmp.sv
hw/rtl/time_slot_table_engine.sv
dv/time_slot_table_engine_test.sv
